// ===== rtl/twu_pkg.sv =====
// ----------------------------------------------------------------------------
// twu_pkg
// Shared types, codes and constants for the timestamp wrap unwrapper.
// ----------------------------------------------------------------------------
package twu_pkg;

   // Width of the stored raw counter. It covers the largest modulus (PCR).
   localparam int unsigned RawW = 42;
   localparam int unsigned TsW  = 63;
   localparam int unsigned TbW  = 32;
   localparam int unsigned GenW = 64;
   localparam int unsigned InW  = 64;

   // Counter moduli. The PCR modulus is 2^33 * 300 at 27 MHz.
   localparam logic [RawW-1:0] RTP_MODULUS = RawW'(64'd1 << 32);
   localparam logic [RawW-1:0] PTS_MODULUS = RawW'(64'd1 << 33);
   localparam logic [RawW-1:0] PCR_MODULUS = RawW'((64'd1 << 33) * 64'd300);

   // Configuration register indexes.
   typedef enum logic {
      CSR_COUNTER_KIND = 1'b0,
      CSR_GENERATION   = 1'b1
   } csr_index_type;

   // Counter kinds. The fourth code has no modulus.
   typedef enum logic [1:0] {
      KIND_RTP = 2'd0,
      KIND_PTS = 2'd1,
      KIND_PCR = 2'd2
   } counter_kind_type;

   // Result reasons.
   typedef enum logic [2:0] {
      REASON_NONE      = 3'd0,
      REASON_RANGE     = 3'd1,
      REASON_TIMEBASE  = 3'd2,
      REASON_AMBIGUOUS = 3'd3,
      REASON_BACKWARD  = 3'd4,
      REASON_OVERFLOW  = 3'd5
   } reason_type;

   // Fields of one input item.
   typedef struct packed {
      logic signed [InW-1:0] raw_ticks;
      logic signed [TbW-1:0] tb_num;
      logic signed [TbW-1:0] tb_den;
   } req_item_type;

   // Fields of one result item.
   typedef struct packed {
      logic                  status;
      logic [2:0]            reason;
      logic [TsW-1:0]        unwrapped_ts;
      logic signed [TbW-1:0] out_tb_num;
      logic signed [TbW-1:0] out_tb_den;
      logic [GenW-1:0]       out_generation;
   } rsp_item_type;

   // Tracking state carried from one item to the next.
   typedef struct packed {
      logic            seeded;
      logic [RawW-1:0] last_raw;
      logic [TsW-1:0]  last_unwrapped;
      logic [TbW-1:0]  held_tb_num;
      logic [TbW-1:0]  held_tb_den;
   } track_state_type;

   localparam track_state_type TRACK_CLEAR = '0;

   // Modulus of a counter kind; zero for the unused code.
   function automatic logic [RawW-1:0] modulus_of(input logic [1:0] kind);
      logic [RawW-1:0] m;
      case (kind)
         KIND_RTP: m = RTP_MODULUS;
         KIND_PTS: m = PTS_MODULUS;
         KIND_PCR: m = PCR_MODULUS;
         default:  m = '0;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/twu_if.sv =====
// ----------------------------------------------------------------------------
// twu_if
// Valid/ready channel interfaces for items, results and register writes.
// ----------------------------------------------------------------------------

// Input item channel.
interface twu_req_if import twu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic signed [InW-1:0] raw_ticks;
   logic signed [TbW-1:0] tb_num;
   logic signed [TbW-1:0] tb_den;

   modport source (output valid, output raw_ticks, output tb_num, output tb_den,
                   input ready);
   modport sink   (input valid, input raw_ticks, input tb_num, input tb_den,
                   output ready);
endinterface

// Result item channel.
interface twu_rsp_if import twu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  status;
   logic [2:0]            reason;
   logic [TsW-1:0]        unwrapped_ts;
   logic signed [TbW-1:0] out_tb_num;
   logic signed [TbW-1:0] out_tb_den;
   logic [GenW-1:0]       out_generation;

   modport source (output valid, output status, output reason, output unwrapped_ts,
                   output out_tb_num, output out_tb_den, output out_generation,
                   input ready);
   modport sink   (input valid, input status, input reason, input unwrapped_ts,
                   input out_tb_num, input out_tb_den, input out_generation,
                   output ready);
endinterface

// Register write channel.
interface twu_csr_if import twu_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            index;
   logic [GenW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/twu_decide.sv =====
// ----------------------------------------------------------------------------
// twu_decide
// Checks one raw sample against the tracking state and forms the next state.
// ----------------------------------------------------------------------------
module twu_decide import twu_pkg::*; (
   input  logic [1:0]      kind,
   input  req_item_type    item,
   input  track_state_type cur,
   output reason_type      reason,
   output track_state_type nxt
);

   logic [RawW-1:0] modulus;
   logic [RawW-1:0] half;
   logic [RawW-1:0] raw;
   logic            out_of_range;
   logic            num_ok;
   logic            den_ok;
   logic            mismatch;
   logic            ahead;
   logic [RawW-1:0] fwd_diff;
   logic [RawW-1:0] back_diff;
   logic [RawW-1:0] forward;
   logic            ambiguous;
   logic            backward;
   logic [TsW:0]    sum;

   assign modulus = modulus_of(kind);
   assign half    = {1'b0, modulus[RawW-1:1]};
   assign raw     = item.raw_ticks[RawW-1:0];

   // A negative or too large sample is out of range; the unused kind rejects all.
   assign out_of_range = item.raw_ticks[InW-1] || (item.raw_ticks[InW-2:RawW] != '0)
                         || (raw >= modulus);

   // The time base must be positive and match the held one once seeded.
   assign num_ok   = !item.tb_num[TbW-1] && (item.tb_num != '0);
   assign den_ok   = !item.tb_den[TbW-1] && (item.tb_den != '0);
   assign mismatch = cur.seeded && ((item.tb_num != cur.held_tb_num) ||
                                    (item.tb_den != cur.held_tb_den));

   // Distance moved, forward directly or across the wrap.
   assign ahead     = raw >= cur.last_raw;
   assign fwd_diff  = raw - cur.last_raw;
   assign back_diff = cur.last_raw - raw;
   assign forward   = ahead ? fwd_diff : (modulus - back_diff);
   assign ambiguous = ahead ? (fwd_diff == half) : (back_diff == half);
   assign backward  = ahead ? (fwd_diff > half) : (back_diff < half);

   // The sum overflows when it no longer fits in the timestamp width.
   assign sum = {1'b0, cur.last_unwrapped} + (TsW+1)'(forward);

   // Checks in priority order; only a good sample changes the state.
   always_comb begin
      nxt    = cur;
      reason = REASON_NONE;
      if (out_of_range) begin
         reason = REASON_RANGE;
      end else if (!num_ok || !den_ok || mismatch) begin
         reason = REASON_TIMEBASE;
      end else if (!cur.seeded) begin
         nxt.seeded         = 1'b1;
         nxt.last_raw       = raw;
         nxt.last_unwrapped = TsW'(raw);
         nxt.held_tb_num    = item.tb_num;
         nxt.held_tb_den    = item.tb_den;
      end else if (ambiguous) begin
         reason = REASON_AMBIGUOUS;
      end else if (backward) begin
         reason = REASON_BACKWARD;
      end else if (sum[TsW]) begin
         reason = REASON_OVERFLOW;
      end else begin
         nxt.last_raw       = raw;
         nxt.last_unwrapped = sum[TsW-1:0];
      end
   end

endmodule

// ===== rtl/timestamp_wrap_unwrapper.sv =====
// ----------------------------------------------------------------------------
// timestamp_wrap_unwrapper
// Extends a wrapping RTP, PTS/DTS or PCR counter into a 63-bit timestamp.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Carries
//   req       in          raw_ticks, tb_num, tb_den
//   rsp       out         status, reason, unwrapped_ts, out_tb_num, out_tb_den,
//                         out_generation
//   csr       in          index (0 counter_kind, 1 generation), data
//
// An item is taken into an input register, checked against the tracking state
// and written to the result register; one item is accepted per cycle while the
// result is not stalled. The tracking state is updated in the same cycle an
// item moves into the result register, so a following item sees it; a register
// write in that cycle clears it instead. A stalled result holds the result
// register and the input register fills behind it. Reset clears the valid
// flags, configuration and tracking state; any register write clears tracking state.
//
module timestamp_wrap_unwrapper import twu_pkg::*; (
   input logic        clock,
   input logic        reset,
   twu_req_if.sink    req_chan,
   twu_rsp_if.source  rsp_chan,
   twu_csr_if.sink    csr_chan
);

   logic            stage_valid_ff;
   logic            stage_valid_in;
   req_item_type    stage_item_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_item_type    rsp_item_ff;
   logic [1:0]      kind_ff;
   logic [GenW-1:0] gen_ff;
   track_state_type state_ff;
   track_state_type state_nxt;
   reason_type      reason;
   logic            advance;
   logic            req_take;
   logic            csr_take;

   // Handshake control: the stage moves on whenever the result slot frees up.
   assign advance        = stage_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_take       = csr_chan.valid;

   assign stage_valid_in = req_take || (stage_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_chan.ready);

   // Sample check and next tracking state.
   twu_decide u_decide (
      .kind   (kind_ff),
      .item   (stage_item_ff),
      .cur    (state_ff),
      .reason (reason),
      .nxt    (state_nxt)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Configuration registers and tracking state.
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_RTP;
         gen_ff   <= '0;
         state_ff <= TRACK_CLEAR;
      end else if (csr_take) begin
         case (csr_chan.index)
            CSR_COUNTER_KIND: kind_ff <= csr_chan.data[1:0];
            CSR_GENERATION:   gen_ff  <= csr_chan.data;
            default:          gen_ff  <= gen_ff;
         endcase
         state_ff <= TRACK_CLEAR;
      end else if (advance) begin
         state_ff <= state_nxt;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_item_ff.raw_ticks <= req_chan.raw_ticks;
         stage_item_ff.tb_num    <= req_chan.tb_num;
         stage_item_ff.tb_den    <= req_chan.tb_den;
      end
   end

   // Result register; the echoed fields reflect the state after this item.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff.status         <= (reason != REASON_NONE);
         rsp_item_ff.reason         <= reason;
         rsp_item_ff.unwrapped_ts   <= state_nxt.last_unwrapped;
         rsp_item_ff.out_tb_num     <= state_nxt.held_tb_num;
         rsp_item_ff.out_tb_den     <= state_nxt.held_tb_den;
         rsp_item_ff.out_generation <= gen_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_item_ff.status;
   assign rsp_chan.reason         = rsp_item_ff.reason;
   assign rsp_chan.unwrapped_ts   = rsp_item_ff.unwrapped_ts;
   assign rsp_chan.out_tb_num     = rsp_item_ff.out_tb_num;
   assign rsp_chan.out_tb_den     = rsp_item_ff.out_tb_den;
   assign rsp_chan.out_generation = rsp_item_ff.out_generation;

endmodule
